// ----- rtl/nnis_pkg.sv -----
`timescale 1ns / 1ps

package nnis_pkg;

    // Field and register widths
    localparam int COORD_W    = 12;
    localparam int PIX_W      = 8;
    localparam int SRC_SZ_W   = 9;
    localparam int DST_SZ_W   = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    // Scaled coordinate is below the source size, so it fits the source size width
    localparam int QUOT_W  = SRC_SZ_W;
    localparam int PROD_W  = COORD_W + SRC_SZ_W;
    localparam int DCNT_W  = $clog2(QUOT_W + 1);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEST_WIDTH    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DEST_HEIGHT   = 2'd3;

    // Request kinds
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_READ  = 1'b1;

    // Register reset values
    localparam logic [SRC_SZ_W-1:0] SRC_SIZE_RESET = 9'd256;
    localparam logic [DST_SZ_W-1:0] DST_SIZE_RESET = 13'd256;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } t_pixel;

endpackage

// ----- rtl/nnis_ram.sv -----
`timescale 1ns / 1ps

module nnis_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/nnis_divider.sv -----
`timescale 1ns / 1ps

module nnis_divider (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [nnis_pkg::PROD_W-1:0]   i_dividend,
    input  logic [nnis_pkg::DST_SZ_W-1:0] i_divisor,
    output logic                          o_done,
    output logic [nnis_pkg::QUOT_W-1:0]   o_quotient
);
    import nnis_pkg::*;

    logic                r_busy;
    logic                r_done;
    logic [DCNT_W-1:0]   r_cnt;
    logic [DST_SZ_W-1:0] r_rem;
    logic [DST_SZ_W-1:0] r_div;
    logic [QUOT_W-1:0]   r_low;
    logic [QUOT_W-1:0]   r_quot;

    logic [DST_SZ_W:0]   shifted;
    logic [DST_SZ_W:0]   diff;
    logic                ge;

    // Restoring step: one quotient bit per cycle.
    // Quotient is known to fit QUOT_W bits, so the upper dividend bits start
    // out below the divisor.
    assign shifted = {r_rem, r_low[QUOT_W-1]};
    assign ge      = shifted >= {1'b0, r_div};
    assign diff    = shifted - {1'b0, r_div};

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DCNT_W'(QUOT_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DCNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= {1'b0, i_dividend[PROD_W-1:QUOT_W]};
            r_low <= i_dividend[QUOT_W-1:0];
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem  <= ge ? diff[DST_SZ_W-1:0] : shifted[DST_SZ_W-1:0];
            r_low  <= {r_low[QUOT_W-2:0], 1'b0};
            r_quot <= {r_quot[QUOT_W-2:0], ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quot;

endmodule

// ----- rtl/nearest_neighbor_image_scaler_top.sv -----
`timescale 1ns / 1ps
// Nearest-neighbor RGB image scaler.
// Request channel: a request is taken on a rising edge with i_start high and
// o_busy low. i_kind selects a pixel write (source column/row plus RGB) or a
// scaled read (destination column/row).
// Writes inside the source size land in the frame memory on the accepting
// edge and return nothing; the next request can follow in the very next cycle.
// A read maps each coordinate as coord * source size / dest size with one
// shared radix-2 divider (one quotient bit per cycle, QUOT_W = 9 bits), x
// first and then y, then reads the frame memory through its registered read
// port, and raises the result strobe o_valid. o_busy stays high until that
// result is out, and the two divisions take up most of a read.
// A read outside the destination size returns black with o_range_error set
// in the cycle right after the accepting edge, without touching the divider.
// Each result is on the outputs for exactly one cycle; the receiver cannot
// stall it.
// Configuration: i_cfg_valid/o_cfg_ready with a register index; ready is
// always high. Write registers only while the block is idle.
// Reset (synchronous, active low) returns to idle and sets all four sizes to
// 256. The frame memory is not cleared; read only pixels already written.

module nearest_neighbor_image_scaler_top #(
    parameter int MAX_SOURCE_WIDTH  = 256,
    parameter int MAX_SOURCE_HEIGHT = 256
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // request channel
    input  logic                            i_start,
    output logic                            o_busy,
    input  logic                            i_kind,
    input  logic [nnis_pkg::COORD_W-1:0]    i_column,
    input  logic [nnis_pkg::COORD_W-1:0]    i_row,
    input  logic [nnis_pkg::PIX_W-1:0]      i_red_in,
    input  logic [nnis_pkg::PIX_W-1:0]      i_green_in,
    input  logic [nnis_pkg::PIX_W-1:0]      i_blue_in,
    // result channel
    output logic                            o_valid,
    output logic [nnis_pkg::PIX_W-1:0]      o_red_out,
    output logic [nnis_pkg::PIX_W-1:0]      o_green_out,
    output logic [nnis_pkg::PIX_W-1:0]      o_blue_out,
    output logic                            o_range_error,
    // configuration channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [nnis_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [nnis_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import nnis_pkg::*;

    localparam int CW    = (MAX_SOURCE_WIDTH > 1) ? $clog2(MAX_SOURCE_WIDTH) : 1;
    localparam int RW    = (MAX_SOURCE_HEIGHT > 1) ? $clog2(MAX_SOURCE_HEIGHT) : 1;
    localparam int AW    = CW + RW;
    localparam int DEPTH = 1 << AW;

    localparam logic [DST_SZ_W-1:0] MAXW = DST_SZ_W'(MAX_SOURCE_WIDTH);
    localparam logic [DST_SZ_W-1:0] MAXH = DST_SZ_W'(MAX_SOURCE_HEIGHT);

    // Sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MULX  = 4'd1;
    localparam logic [3:0] S_DIVX0 = 4'd2;
    localparam logic [3:0] S_DIVX  = 4'd3;
    localparam logic [3:0] S_MULY  = 4'd4;
    localparam logic [3:0] S_DIVY0 = 4'd5;
    localparam logic [3:0] S_DIVY  = 4'd6;
    localparam logic [3:0] S_READ  = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;

    logic [3:0]          r_state;
    logic [3:0]          n_state;

    logic [SRC_SZ_W-1:0] r_src_w;
    logic [SRC_SZ_W-1:0] r_src_h;
    logic [DST_SZ_W-1:0] r_dst_w;
    logic [DST_SZ_W-1:0] r_dst_h;

    logic [COORD_W-1:0]  r_col;
    logic [COORD_W-1:0]  r_row;
    logic                r_err;
    logic [PROD_W-1:0]   r_prod;
    logic [QUOT_W-1:0]   r_sx;
    logic [QUOT_W-1:0]   r_sy;

    logic [SRC_SZ_W-1:0] sw;
    logic [SRC_SZ_W-1:0] sh;
    logic                accept;
    logic                in_src;
    logic                out_dst;
    logic                mem_we;
    logic [AW-1:0]       waddr;
    logic [AW-1:0]       raddr;
    t_pixel              wpix;
    t_pixel              rpix;
    logic [COORD_W-1:0]  x_full;
    logic [COORD_W-1:0]  y_full;

    logic [COORD_W-1:0]  mul_a;
    logic [SRC_SZ_W-1:0] mul_b;
    logic                div_start;
    logic                div_done;
    logic [DST_SZ_W-1:0] div_divisor;
    logic [QUOT_W-1:0]   div_quot;
    logic [QUOT_W-1:0]   quot_clamped;
    logic [SRC_SZ_W-1:0] clamp_sz;

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w <= SRC_SIZE_RESET;
            r_src_h <= SRC_SIZE_RESET;
            r_dst_w <= DST_SIZE_RESET;
            r_dst_h <= DST_SIZE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_SOURCE_WIDTH:  r_src_w <= i_cfg_data[SRC_SZ_W-1:0];
                REG_SOURCE_HEIGHT: r_src_h <= i_cfg_data[SRC_SZ_W-1:0];
                REG_DEST_WIDTH:    r_dst_w <= i_cfg_data;
                REG_DEST_HEIGHT:   r_dst_h <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Effective source size, saturated to 1..max
    always_comb begin
        if (r_src_w == '0) begin
            sw = SRC_SZ_W'(1);
        end else if ({{(DST_SZ_W-SRC_SZ_W){1'b0}}, r_src_w} > MAXW) begin
            sw = MAXW[SRC_SZ_W-1:0];
        end else begin
            sw = r_src_w;
        end
        if (r_src_h == '0) begin
            sh = SRC_SZ_W'(1);
        end else if ({{(DST_SZ_W-SRC_SZ_W){1'b0}}, r_src_h} > MAXH) begin
            sh = MAXH[SRC_SZ_W-1:0];
        end else begin
            sh = r_src_h;
        end
    end

    // Request decode
    assign accept  = i_start && !o_busy;
    assign in_src  = ({1'b0, i_column} < {{(DST_SZ_W-SRC_SZ_W){1'b0}}, sw})
                  && ({1'b0, i_row} < {{(DST_SZ_W-SRC_SZ_W){1'b0}}, sh});
    assign out_dst = ({1'b0, i_column} >= r_dst_w) || ({1'b0, i_row} >= r_dst_h);

    // Pixel writes go straight to memory on the accepting edge
    assign mem_we     = accept && (i_kind == KIND_WRITE) && in_src;
    assign waddr      = {i_row[RW-1:0], i_column[CW-1:0]};
    assign wpix.red   = i_red_in;
    assign wpix.green = i_green_in;
    assign wpix.blue  = i_blue_in;

    // Scaled read address
    assign x_full = {{(COORD_W-QUOT_W){1'b0}}, r_sx};
    assign y_full = {{(COORD_W-QUOT_W){1'b0}}, r_sy};
    assign raddr  = {y_full[RW-1:0], x_full[CW-1:0]};

    nnis_ram #(
        .WIDTH ($bits(t_pixel)),
        .DEPTH (DEPTH)
    ) u_frame (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (waddr),
        .i_wdata (wpix),
        .i_raddr (raddr),
        .o_rdata (rpix)
    );

    // Shared multiplier and divider, x pass then y pass
    assign mul_a       = (r_state == S_MULX) ? r_col : r_row;
    assign mul_b       = (r_state == S_MULX) ? sw : sh;
    assign div_start   = (r_state == S_DIVX0) || (r_state == S_DIVY0);
    assign div_divisor = (r_state == S_DIVX0) ? r_dst_w : r_dst_h;

    nnis_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_prod),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quot)
    );

    // Clamp to the last source column or row
    assign clamp_sz     = (r_state == S_DIVX) ? sw : sh;
    assign quot_clamped = (div_quot >= clamp_sz) ? clamp_sz - 1'b1 : div_quot;

    // Sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept && (i_kind == KIND_READ)) begin
                    n_state = out_dst ? S_OUT : S_MULX;
                end
            end
            S_MULX:  n_state = S_DIVX0;
            S_DIVX0: n_state = S_DIVX;
            S_DIVX:  n_state = div_done ? S_MULY : S_DIVX;
            S_MULY:  n_state = S_DIVY0;
            S_DIVY0: n_state = S_DIVY;
            S_DIVY:  n_state = div_done ? S_READ : S_DIVY;
            S_READ:  n_state = S_OUT;
            S_OUT:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Read datapath
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_col <= i_column;
            r_row <= i_row;
            r_err <= out_dst;
        end
        if ((r_state == S_MULX) || (r_state == S_MULY)) begin
            r_prod <= {{SRC_SZ_W{1'b0}}, mul_a} * {{COORD_W{1'b0}}, mul_b};
        end
        if ((r_state == S_DIVX) && div_done) begin
            r_sx <= quot_clamped;
        end
        if ((r_state == S_DIVY) && div_done) begin
            r_sy <= quot_clamped;
        end
    end

    // Result
    assign o_busy        = (r_state != S_IDLE);
    assign o_valid       = (r_state == S_OUT);
    assign o_red_out     = r_err ? '0 : rpix.red;
    assign o_green_out   = r_err ? '0 : rpix.green;
    assign o_blue_out    = r_err ? '0 : rpix.blue;
    assign o_range_error = r_err;

endmodule

// ----- rtl/nnis_checker.sv -----
`timescale 1ns / 1ps

module nnis_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic                       o_busy,
    input  logic                       i_kind,
    input  logic                       o_valid,
    input  logic [nnis_pkg::PIX_W-1:0] o_red_out,
    input  logic [nnis_pkg::PIX_W-1:0] o_green_out,
    input  logic [nnis_pkg::PIX_W-1:0] o_blue_out,
    input  logic                       o_range_error
);
    import nnis_pkg::*;

    // A result only appears while a read is in flight
    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_busy)
        else $error("result strobe while idle");

    // Out-of-range reads return black
    a_err_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_range_error) |->
        (o_red_out == '0 && o_green_out == '0 && o_blue_out == '0))
        else $error("range error result is not black");

    // The result cycle ends the request: block is idle right after
    a_valid_then_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> (!o_busy && !o_valid))
        else $error("block still busy after result");

    // Pixel writes complete on the accepting edge
    a_write_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && i_kind == KIND_WRITE) |=> (!o_busy && !o_valid))
        else $error("pixel write held the block or produced a result");

endmodule

bind nearest_neighbor_image_scaler_top nnis_checker u_nnis_checker (.*);
